@@ rtl/swm_pkg.sv @@
// Shared constants for the sliding window median block.
// No dependencies.
`default_nettype none

package swm_pkg;

    localparam int CFG_BITS = 6;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = CFG_BITS'(3);

endpackage

`default_nettype wire

@@ rtl/swm_sorter.sv @@
// Sorted window cells, raw sample history and fill control.
// Depends on swm_pkg for the window size register width and reset value.
`default_nettype none

module swm_sorter
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int KW          = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   window_size_we,
    input  wire logic [CFG_BITS-1:0]                    window_size,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]          sample,
    input  wire logic                                   start_of_sequence,
    input  wire logic                                   pend_ready,
    output logic                                        pend_valid,
    output logic [KW-1:0]                               size_k,
    output logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]      store
);

    localparam int W  = MAX_WINDOW;
    localparam int IW = (W > 1) ? $clog2(W) : 1;
    localparam int WS = (CFG_BITS > KW) ? CFG_BITS : KW;

    logic [CFG_BITS-1:0]                 window_size_reg;
    logic [KW-1:0]                       fill_reg;
    logic [KW-1:0]                       fill_next;
    logic                                pend_valid_reg;
    logic [W-1:0][SAMPLE_BITS-1:0]       store_reg;
    logic [W-1:0][SAMPLE_BITS-1:0]       store_next;
    logic [SAMPLE_BITS-1:0]              hist_reg [W];

    logic [KW-1:0]                       k;
    logic [KW-1:0]                       k_minus1;
    logic                                accept;
    logic [KW-1:0]                       fill_eff;
    logic                                full;
    logic [KW-1:0]                       cnt_after_rem;
    logic signed [SAMPLE_BITS-1:0]       old_val;
    logic [W-1:0]                        kmask;
    logic [W-1:0]                        eqv;
    logic [W-1:0]                        first_eq;
    logic [W-1:0]                        rmask;
    logic [W-1:0]                        ltv;
    logic [W-1:0]                        ltr;
    logic [W-1:0]                        pmask;
    logic [W-1:0][SAMPLE_BITS-1:0]       rem;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = KW'(1);
        end
        else if (WS'(window_size_reg) > WS'(W))
        begin
            k = KW'(W);
        end
        else
        begin
            k = KW'(window_size_reg);
        end
    end

    assign k_minus1   = k - KW'(1);
    assign accept     = in_valid && !in_stall;
    assign in_stall   = pend_valid_reg && !pend_ready;
    assign fill_eff   = start_of_sequence ? '0 : fill_reg;
    assign full       = (fill_eff == k);
    assign cnt_after_rem = full ? k_minus1 : fill_eff;
    assign old_val    = $signed(hist_reg[k_minus1[IW-1:0]]);
    assign fill_next  = full ? k : fill_eff + KW'(1);

    // Parallel compares across all cells
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            kmask[i] = (KW'(i) < k);
            eqv[i]   = full && kmask[i] && ($signed(store_reg[i]) == old_val);
            ltv[i]   = ($signed(store_reg[i]) < sample);
        end
    end

    // Remove one copy of the leaving value; fall back to the last entry
    always_comb
    begin
        first_eq = eqv & (~eqv + W'(1));
        if (!full)
        begin
            rmask = '1;
        end
        else if (|eqv)
        begin
            rmask = first_eq - W'(1);
        end
        else
        begin
            rmask = kmask >> 1;
        end
    end

    always_comb
    begin
        int up;
        for (int i = 0; i < W; i++)
        begin
            up     = (i < W - 1) ? i + 1 : i;
            rem[i] = rmask[i] ? store_reg[i] : store_reg[up];
            ltr[i] = rmask[i] ? ltv[i] : ltv[up];
            pmask[i] = ltr[i] && (KW'(i) < cnt_after_rem);
        end
    end

    // Insert the new value before any equal values
    always_comb
    begin
        int dn;
        logic prev_p;
        for (int i = 0; i < W; i++)
        begin
            dn     = (i > 0) ? i - 1 : 0;
            prev_p = (i == 0) ? 1'b1 : pmask[dn];
            if (pmask[i])
            begin
                store_next[i] = rem[i];
            end
            else if (prev_p)
            begin
                store_next[i] = sample;
            end
            else
            begin
                store_next[i] = rem[dn];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (window_size_we)
            begin
                window_size_reg <= window_size;
                fill_reg        <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end

            if (accept)
            begin
                pend_valid_reg <= (fill_next == k);
            end
            else if (pend_ready)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg  <= store_next;
            hist_reg[0] <= sample;
            for (int i = 1; i < W; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign pend_valid = pend_valid_reg;
    assign size_k     = k;
    assign store      = store_reg;

endmodule

`default_nettype wire

@@ rtl/swm_median_out.sv @@
// Middle-value select and the result register.
// Takes the sorted window from swm_sorter; no package dependency.
`default_nettype none

module swm_median_out #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int KW          = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   pend_valid,
    output logic                                        pend_ready,
    input  wire logic [KW-1:0]                          size_k,
    input  wire logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] store,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [SAMPLE_BITS:0]                 median_doubled
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS:0]   median_reg;
    logic signed [SAMPLE_BITS:0]   median_next;
    logic [KW-1:0]                 lo_idx;
    logic [KW-1:0]                 hi_idx;
    logic [SAMPLE_BITS-1:0]        lo_val;
    logic [SAMPLE_BITS-1:0]        hi_val;

    assign lo_idx      = (size_k - KW'(1)) >> 1;
    assign hi_idx      = size_k >> 1;
    assign lo_val      = store[lo_idx[IW-1:0]];
    assign hi_val      = store[hi_idx[IW-1:0]];
    assign median_next = $signed({lo_val[SAMPLE_BITS-1], lo_val})
                       + $signed({hi_val[SAMPLE_BITS-1], hi_val});
    assign pend_ready  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_ready)
        begin
            out_valid_reg <= pend_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_ready && pend_valid)
        begin
            median_reg <= median_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

endmodule

`default_nettype wire

@@ rtl/sliding_window_median.sv @@
// Top level of the sliding window median block.
// Depends on swm_pkg, swm_sorter and swm_median_out.
//
// Running median over the last window_size samples (1 to MAX_WINDOW; zero acts as 1,
// larger values as MAX_WINDOW). One item is taken every clock unless in_stall is set;
// its result, twice the median, goes from the sorted window cells to the result
// register. The rate is set by the sorted window cells, which remove the leaving value
// and insert the new one in a single compare-and-shift update; the middle-value select
// and add sit in the next stage. No result is given until the window is full. Writing
// window_size, or an item with start_of_sequence set, empties the window. Input stalls
// only while the result register is stalled and the sorted window cells hold a result.
`default_nettype none

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          window_size_we,
    input  wire logic [CFG_BITS-1:0]           window_size,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          start_of_sequence,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS:0]        median_doubled
);

    localparam int KW = $clog2(MAX_WINDOW + 1);

    logic                                   pend_valid;
    logic                                   pend_ready;
    logic [KW-1:0]                          size_k;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] store;

    swm_sorter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .KW          (KW)
    ) u_sorter (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size       (window_size),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .start_of_sequence (start_of_sequence),
        .pend_ready        (pend_ready),
        .pend_valid        (pend_valid),
        .size_k            (size_k),
        .store             (store)
    );

    swm_median_out #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .KW          (KW)
    ) u_median_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .pend_valid     (pend_valid),
        .pend_ready     (pend_ready),
        .size_k         (size_k),
        .store          (store),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .median_doubled (median_doubled)
    );

endmodule

`default_nettype wire
